>>> hdl/orlb_pkg.sv
`default_nettype none
package orlb_pkg;

	// Ring geometry and request limit.
	localparam int RING_DEPTH  = 4096;
	localparam int MAX_REQUEST = 64;

	// Derived widths.
	localparam int IDX_W  = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int LEN_W  = $clog2(MAX_REQUEST + 1);
	localparam int NUM_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;

	// Field widths of the item formats.
	localparam int KIND_W = 3;
	localparam int BYTE_W = 8;
	localparam int REQ_W  = 7;
	localparam int CUR_W  = 64;
	localparam int DROP_W = 32;

	// Item kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE = 3'd0,
		KIND_READ  = 3'd1,
		KIND_SNAP  = 3'd2,
		KIND_TAIL  = 3'd3,
		KIND_CLEAR = 3'd4
	} orlb_kind_t;

	// Control sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SNAP_LOW,
		ST_SNAP_HIGH,
		ST_SNAP_LEN,
		ST_SNAP_POS,
		ST_RUN
	} orlb_state_t;

	// One input item.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data_byte;
		logic              write_last;
		logic [REQ_W-1:0]  request_length;
		logic [CUR_W-1:0]  seek_pos;
	} orlb_in_t;

	// One result item.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
		logic              empty_res;
		logic [CUR_W-1:0]  first_pos;
		logic [CUR_W-1:0]  resume_pos;
		logic [CUR_W-1:0]  newest_pos;
		logic [FILL_W-1:0] fill_count;
		logic [DROP_W-1:0] overflow_count;
	} orlb_out_t;

	// Step a ring index by one, wrapping at the ring depth.
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == IDX_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + IDX_W'(1);
		end
		return r;
	endfunction

	// Ring index plus a distance of at most the ring depth.
	function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
			input logic [FILL_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + (IDX_W+1)'(b);
		if (s >= (IDX_W+1)'(RING_DEPTH)) begin
			s = s - (IDX_W+1)'(RING_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	// Ring index minus a distance of at most the ring depth.
	function automatic logic [IDX_W-1:0] idx_sub(input logic [IDX_W-1:0] a,
			input logic [FILL_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + (IDX_W+1)'(RING_DEPTH) - (IDX_W+1)'(b);
		if (s >= (IDX_W+1)'(RING_DEPTH)) begin
			s = s - (IDX_W+1)'(RING_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/orlb_ram.sv
`default_nettype none
module orlb_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/orlb_fifo.sv
`default_nettype none
module orlb_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire orlb_pkg::orlb_out_t push_item,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      orlb_pkg::orlb_out_t out_item,
	output      logic [1:0]          level
);
	import orlb_pkg::*;

	orlb_out_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = ent_q[rd_q];
	assign level     = cnt_q;
	assign pop       = out_valid && out_ready;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	// The read scheduler must never push into a full buffer that is not draining.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push && cnt_q == 2'd2 |-> pop)
		else $error("result buffer overrun");
`endif

endmodule
`default_nettype wire

>>> hdl/overwrite_ring_log_buffer.sv
`default_nettype none
// Byte trace ring of RING_DEPTH entries that overwrites its oldest byte when full,
// with a wrapping drop counter and a 64-bit written total used as a byte cursor.
// Write items stream bytes in at one per clock while no other item is in progress.
// A drain, snapshot or tail item returning n bytes is accepted and then issues
// max(n, 1) reads of the ring memory, one per cycle while the result buffer has
// room. Each byte passes from the registered memory read into a two-entry result
// buffer that absorbs output stalls; while that buffer is full the next read
// waits. A snapshot first clamps its start cursor to the oldest cursor and the
// written total, then sets its length, ring offset and read pointer before its
// reads begin. Clear and unknown kinds give no result. The next item is
// accepted in the cycle after the last read of the current one has been issued,
// even while its results still wait in the buffer. The ring memory is not
// cleared after reset; only bytes that were written are ever returned.
module overwrite_ring_log_buffer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire orlb_pkg::orlb_in_t  in_item,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      orlb_pkg::orlb_out_t out_item
);
	import orlb_pkg::*;

	// Control and pointer state.
	orlb_state_t       state_q, state_d;
	logic [IDX_W-1:0]  head_q, tail_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [DROP_W-1:0] drop_q;
	logic [CUR_W-1:0]  written_q;

	// Per-request working registers.
	logic [LEN_W-1:0]  rem_q, req_q;
	logic              empty_q;
	logic [CUR_W-1:0]  since_q, oldest_q, start_q;
	logic [IDX_W-1:0]  off_q;
	orlb_out_t         meta_q;

	// Read stage aligned with the memory latency.
	logic              valid_s1;
	orlb_out_t         res_s1;

	logic              accept, issue, last_i, ram_we, pop, full;
	logic [LEN_W-1:0]  req_sat;
	logic [NUM_W-1:0]  n_avail;
	logic [CUR_W-1:0]  avail;
	logic [LEN_W-1:0]  n_snap;
	logic [2:0]        occ;
	logic [1:0]        level;
	logic [BYTE_W-1:0] rdata;
	orlb_out_t         push_item;
	orlb_out_t         meta_new, meta_snap, res_d;

	// Request length saturated to the largest request, and the bytes available for it.
	always_comb begin
		if (in_item.request_length > REQ_W'(MAX_REQUEST)) begin
			req_sat = LEN_W'(MAX_REQUEST);
		end else begin
			req_sat = LEN_W'(in_item.request_length);
		end
		if (NUM_W'(fill_q) < NUM_W'(req_sat)) begin
			n_avail = NUM_W'(fill_q);
		end else begin
			n_avail = NUM_W'(req_sat);
		end
	end

	// Snapshot length from the clamped start cursor.
	always_comb begin
		avail = written_q - start_q;
		if (avail < CUR_W'(req_q)) begin
			n_snap = LEN_W'(avail);
		end else begin
			n_snap = req_q;
		end
	end

	// Result fields for a new request, and the cursors a snapshot adds to them.
	always_comb begin
		meta_new                = '0;
		meta_new.overflow_count = drop_q;
		if (in_item.kind == KIND_READ) begin
			meta_new.fill_count = fill_q - FILL_W'(n_avail);
		end else begin
			meta_new.fill_count = fill_q;
		end
		meta_snap            = meta_q;
		meta_snap.first_pos  = start_q;
		meta_snap.resume_pos = start_q + CUR_W'(rem_q);
		meta_snap.newest_pos = written_q;
		res_d                = meta_q;
		res_d.last           = last_i;
		res_d.empty_res      = empty_q;
	end

	// Read scheduling keeps the result buffer from overrunning.
	assign pop    = out_valid && out_ready;
	assign occ    = 3'(level) + 3'(valid_s1) - 3'(pop);
	assign last_i = empty_q || (rem_q == LEN_W'(1));
	assign accept = in_valid && in_ready;
	assign full   = (fill_q == FILL_W'(RING_DEPTH));
	assign ram_we = accept && (in_item.kind == KIND_WRITE);

	// Next state and handshake.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (orlb_kind_t'(in_item.kind))
						KIND_READ: state_d = ST_RUN;
						KIND_TAIL: state_d = ST_RUN;
						KIND_SNAP: state_d = ST_SNAP_LOW;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SNAP_LOW:  state_d = ST_SNAP_HIGH;
			ST_SNAP_HIGH: state_d = ST_SNAP_LEN;
			ST_SNAP_LEN:  state_d = ST_SNAP_POS;
			ST_SNAP_POS:  state_d = ST_RUN;
			ST_RUN: begin
				issue = (occ < 3'd2);
				if (issue && last_i) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Ring pointers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			drop_q    <= '0;
			written_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (accept) begin
				case (orlb_kind_t'(in_item.kind))
					KIND_WRITE: begin
						if (full) begin
							tail_q <= idx_inc(tail_q);
							drop_q <= drop_q + DROP_W'(1);
						end else begin
							fill_q <= fill_q + FILL_W'(1);
						end
						head_q    <= idx_inc(head_q);
						written_q <= written_q + CUR_W'(1);
					end
					KIND_READ: begin
						tail_q <= idx_add(tail_q, FILL_W'(n_avail));
						fill_q <= fill_q - FILL_W'(n_avail);
					end
					KIND_CLEAR: begin
						head_q <= '0;
						tail_q <= '0;
						fill_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Request setup, snapshot cursor arithmetic and read stepping.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q    <= req_sat;
				since_q  <= in_item.seek_pos;
				oldest_q <= written_q - CUR_W'(fill_q);
				rem_q    <= LEN_W'(n_avail);
				empty_q  <= (n_avail == '0);
				meta_q   <= meta_new;
				if (in_item.kind == KIND_READ) begin
					rd_ptr_q <= tail_q;
				end else begin
					rd_ptr_q <= idx_sub(head_q, FILL_W'(n_avail));
				end
			end
			ST_SNAP_LOW: begin
				start_q <= (since_q < oldest_q) ? oldest_q : since_q;
			end
			ST_SNAP_HIGH: begin
				if (start_q > written_q) begin
					start_q <= written_q;
				end
			end
			ST_SNAP_LEN: begin
				rem_q   <= n_snap;
				empty_q <= (n_snap == '0);
				off_q   <= IDX_W'(start_q - oldest_q);
			end
			ST_SNAP_POS: begin
				rd_ptr_q <= idx_add(tail_q, FILL_W'(off_q));
				meta_q   <= meta_snap;
			end
			ST_RUN: begin
				if (issue) begin
					rd_ptr_q <= idx_inc(rd_ptr_q);
					if (!empty_q) begin
						rem_q <= rem_q - LEN_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields travel with the memory read.
	always_ff @(posedge clk) begin
		if (issue) begin
			res_s1 <= res_d;
		end
	end

	// Merge the read byte into the result.
	always_comb begin
		push_item          = res_s1;
		push_item.out_byte = res_s1.empty_res ? '0 : rdata;
	end

	orlb_ram #(
		.DEPTH(RING_DEPTH),
		.WIDTH(BYTE_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (in_item.data_byte),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	orlb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_item (push_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.level     (level)
	);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("fill level above ring depth");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && issue))
		else $error("ring write overlaps a read");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		issue && last_i |=> state_q == ST_IDLE)
		else $error("request did not finish after its last read");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.empty_res |-> res_s1.last)
		else $error("empty result not marked last");
`endif

endmodule
`default_nettype wire
